@@ hdl/pcds_pkg.sv @@
// Shared types, constants and the tested-settings ROM for the PLL divider search.
`timescale 1ns / 1ps

package pcds_pkg;

    localparam int KHZ_W       = 18;
    localparam int NUM_W       = 7;
    localparam int DEN_W       = 6;
    localparam int WINDOW_W    = 9;
    localparam int DIVIDEND_W  = 22;
    localparam int DIVISOR_W   = 10;
    localparam int DIV_STEPS   = DIVIDEND_W;
    localparam int ROM_SIZE    = 28;
    localparam int ROM_IDX_W   = 5;

    localparam logic [KHZ_W-1:0]     OSC_KHZ        = 18'd28636;
    localparam logic [KHZ_W-1:0]     CEIL_FLOOR_KHZ = 18'd111000;
    localparam logic [DIVISOR_W-1:0] WINDOW_DIV     = 10'd1000;
    localparam logic [NUM_W-1:0]     NUM_FIRST      = 7'h10;
    localparam logic [NUM_W-1:0]     NUM_LAST       = 7'h7e;
    localparam logic [DEN_W-1:0]     DEN_FIRST      = 6'h14;
    localparam logic [DEN_W-1:0]     DEN_LAST       = 6'h3e;
    localparam logic [DEN_W-1:0]     DEN_MASK       = 6'h3e;

    typedef struct packed {
        logic [KHZ_W-1:0] target_khz;
        logic [KHZ_W-1:0] vco_ceiling_khz;
    } t_request;

    typedef struct packed {
        logic             found;
        logic [KHZ_W-1:0] reached_khz;
        logic [NUM_W-1:0] numerator;
        logic [DEN_W-1:0] denominator;
    } t_result;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic [KHZ_W-1:0] khz;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_setting;

    function automatic t_setting rom_setting(input logic [ROM_IDX_W-1:0] idx);
        t_setting s;
        case (idx)
            5'd0:    s = '{18'd12599,  7'h2c, 6'h33};
            5'd1:    s = '{18'd25226,  7'h4a, 6'h2b};
            5'd2:    s = '{18'd28324,  7'h5b, 6'h2f};
            5'd3:    s = '{18'd31499,  7'h42, 6'h1f};
            5'd4:    s = '{18'd36081,  7'h7e, 6'h33};
            5'd5:    s = '{18'd39991,  7'h51, 6'h3a};
            5'd6:    s = '{18'd41164,  7'h45, 6'h30};
            5'd7:    s = '{18'd45075,  7'h55, 6'h36};
            5'd8:    s = '{18'd49866,  7'h65, 6'h3a};
            5'd9:    s = '{18'd64981,  7'h76, 6'h34};
            5'd10:   s = '{18'd72162,  7'h7e, 6'h32};
            5'd11:   s = '{18'd74999,  7'h6e, 6'h2a};
            5'd12:   s = '{18'd80012,  7'h5f, 6'h22};
            5'd13:   s = '{18'd85226,  7'h7d, 6'h2a};
            5'd14:   s = '{18'd89998,  7'h58, 6'h1c};
            5'd15:   s = '{18'd95019,  7'h49, 6'h16};
            5'd16:   s = '{18'd100226, 7'h46, 6'h14};
            5'd17:   s = '{18'd108035, 7'h53, 6'h16};
            5'd18:   s = '{18'd109771, 7'h5c, 6'h18};
            5'd19:   s = '{18'd120050, 7'h6d, 6'h1a};
            5'd20:   s = '{18'd125998, 7'h58, 6'h14};
            5'd21:   s = '{18'd130055, 7'h6d, 6'h18};
            5'd22:   s = '{18'd134998, 7'h42, 6'h0e};
            5'd23:   s = '{18'd150339, 7'h69, 6'h14};
            5'd24:   s = '{18'd168236, 7'h5e, 6'h10};
            5'd25:   s = '{18'd188179, 7'h5c, 6'h0e};
            5'd26:   s = '{18'd210679, 7'h67, 6'h0e};
            5'd27:   s = '{18'd229088, 7'h60, 6'h0c};
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

@@ hdl/pcds_divider.sv @@
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module pcds_divider
    import pcds_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_count;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_divisor;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    trial_sub;
    logic                  ge;

    // The quotient register starts out holding the dividend; its top bit is
    // shifted into the remainder while the quotient bit enters at the bottom.
    always_comb begin
        trial     = {r_rem, r_quo[DIVIDEND_W-1]};
        ge        = (trial >= {1'b0, r_divisor});
        trial_sub = trial - {1'b0, r_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy    <= 1'b1;
                r_count   <= '0;
                r_quo     <= i_req.dividend;
                r_rem     <= '0;
                r_divisor <= i_req.divisor;
            end else if (r_busy) begin
                r_rem   <= ge ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
                r_quo   <= {r_quo[DIVIDEND_W-2:0], ge};
                r_count <= r_count + 1'b1;
                if (r_count == CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

@@ hdl/pll_clock_divider_search.sv @@
// Top level of the PLL numerator/denominator search with its sequencer.
`timescale 1ns / 1ps

// A request (start high while busy is low) gives a target clock and a VCO
// ceiling; one result comes back on o_result for a single cycle, marked by
// o_result_valid, and must be taken in that cycle. All divisions run through
// one shared 22-bit restoring divider that yields one quotient bit per cycle.
// The window target/1000 takes one division, then the tested-settings ROM
// is scanned at one entry per cycle. A miss runs the full search over 111
// numerators by 43 denominators, one division per pair. busy stays high for
// the whole search, and a new request may be given in the cycle that the
// result shows.

module pll_clock_divider_search
    import pcds_pkg::*;
#(
    parameter int TESTED_ENTRIES = 28
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_request i_request,
    output logic     busy,
    output logic     o_result_valid,
    output t_result  o_result
);

    localparam int SCAN_LEN = (TESTED_ENTRIES < ROM_SIZE) ? TESTED_ENTRIES : ROM_SIZE;
    localparam logic [ROM_IDX_W-1:0] SCAN_LAST = ROM_IDX_W'(SCAN_LEN - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WINDOW,
        S_ROM,
        S_DIV,
        S_EVAL
    } t_state;

    t_state                r_state, n_state;
    logic [KHZ_W-1:0]      r_target, n_target;
    logic [KHZ_W-1:0]      r_ceiling, n_ceiling;
    logic [WINDOW_W-1:0]   r_window, n_window;
    logic [ROM_IDX_W-1:0]  r_idx, n_idx;
    logic [NUM_W-1:0]      r_n, n_n;
    logic [DEN_W-1:0]      r_d, n_d;
    logic [KHZ_W-1:0]      r_best_diff, n_best_diff;
    logic [KHZ_W-1:0]      r_best_khz, n_best_khz;
    logic [NUM_W-1:0]      r_best_n, n_best_n;
    logic [DEN_W-1:0]      r_best_d, n_best_d;
    logic                  r_have, n_have;
    t_div_req              r_div_req, n_div_req;
    t_result               r_result, n_result;
    logic                  r_result_valid, n_result_valid;

    t_div_rsp              div_rsp;
    t_setting              entry;
    logic [DIVIDEND_W-1:0] vco;
    logic                  in_range;
    logic [KHZ_W-1:0]      clk_khz;
    logic [KHZ_W-1:0]      diff;
    logic                  better;

    function automatic logic [KHZ_W-1:0] abs_diff(input logic [KHZ_W-1:0] a,
                                                  input logic [KHZ_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    pcds_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        entry    = rom_setting(r_idx);
        vco      = div_rsp.quotient;
        in_range = (vco >= DIVIDEND_W'(OSC_KHZ)) && (vco <= DIVIDEND_W'(r_ceiling));
        // In range means vco is below 2^18, so the shifted clock fits.
        clk_khz  = r_d[0] ? vco[KHZ_W:1] : vco[KHZ_W-1:0];
        diff     = abs_diff(clk_khz, r_target);
        better   = in_range && (diff < r_best_diff);
    end

    always_comb begin
        n_state        = r_state;
        n_target       = r_target;
        n_ceiling      = r_ceiling;
        n_window       = r_window;
        n_idx          = r_idx;
        n_n            = r_n;
        n_d            = r_d;
        n_best_diff    = r_best_diff;
        n_best_khz     = r_best_khz;
        n_best_n       = r_best_n;
        n_best_d       = r_best_d;
        n_have         = r_have;
        n_div_req      = r_div_req;
        n_div_req.start = 1'b0;
        n_result       = r_result;
        n_result_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_target  = i_request.target_khz;
                    n_ceiling = (i_request.vco_ceiling_khz < CEIL_FLOOR_KHZ) ?
                                CEIL_FLOOR_KHZ : i_request.vco_ceiling_khz;
                    n_div_req.start    = 1'b1;
                    n_div_req.dividend = DIVIDEND_W'(i_request.target_khz);
                    n_div_req.divisor  = WINDOW_DIV;
                    n_state = S_WINDOW;
                end
            end
            S_WINDOW: begin
                if (div_rsp.done) begin
                    n_window = div_rsp.quotient[WINDOW_W-1:0];
                    n_idx    = '0;
                    n_state  = S_ROM;
                end
            end
            S_ROM: begin
                if (abs_diff(entry.khz, r_target) < KHZ_W'(r_window)) begin
                    n_result       = '{1'b1, entry.khz, entry.num, entry.den};
                    n_result_valid = 1'b1;
                    n_state        = S_IDLE;
                end else if (r_idx == SCAN_LAST) begin
                    n_n         = NUM_FIRST;
                    n_d         = DEN_FIRST;
                    n_best_diff = r_target;
                    n_best_khz  = '0;
                    n_best_n    = '0;
                    n_best_d    = '0;
                    n_have      = 1'b0;
                    n_div_req.start    = 1'b1;
                    n_div_req.dividend = DIVIDEND_W'(NUM_FIRST) * DIVIDEND_W'(OSC_KHZ);
                    n_div_req.divisor  = DIVISOR_W'(DEN_FIRST & DEN_MASK);
                    n_state = S_DIV;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (better) begin
                    n_best_diff = diff;
                    n_best_khz  = clk_khz;
                    n_best_n    = r_n;
                    n_best_d    = r_d;
                    n_have      = 1'b1;
                end
                if ((r_d == DEN_LAST) && (r_n == NUM_LAST)) begin
                    if (better) begin
                        n_result = '{1'b1, clk_khz, r_n, r_d};
                    end else begin
                        n_result = '{r_have, r_best_khz, r_best_n, r_best_d};
                    end
                    n_result_valid = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    if (r_d == DEN_LAST) begin
                        n_n = r_n + 1'b1;
                        n_d = DEN_FIRST;
                    end else begin
                        n_d = r_d + 1'b1;
                    end
                    n_div_req.start    = 1'b1;
                    n_div_req.dividend = DIVIDEND_W'(n_n) * DIVIDEND_W'(OSC_KHZ);
                    n_div_req.divisor  = DIVISOR_W'(n_d & DEN_MASK);
                    n_state = S_DIV;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_result_valid  <= 1'b0;
            r_div_req.start <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_result_valid  <= n_result_valid;
            r_div_req.start <= n_div_req.start;
        end
        r_target           <= n_target;
        r_ceiling          <= n_ceiling;
        r_window           <= n_window;
        r_idx              <= n_idx;
        r_n                <= n_n;
        r_d                <= n_d;
        r_best_diff        <= n_best_diff;
        r_best_khz         <= n_best_khz;
        r_best_n           <= n_best_n;
        r_best_d           <= n_best_d;
        r_have             <= n_have;
        r_div_req.dividend <= n_div_req.dividend;
        r_div_req.divisor  <= n_div_req.divisor;
        r_result           <= n_result;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    a_result_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held longer than one cycle");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while still busy");

    a_found_clock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.found) |-> (o_result.reached_khz != '0))
        else $error("found result with zero clock");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.found) |->
            ((o_result.reached_khz == '0) && (o_result.numerator == '0)))
        else $error("failure result carries a setting");

endmodule
